@@ rtl/cigar_reference_span_tracker_top_defines.svh @@
// Assertion macros shared by the span tracker modules.
`ifndef CIGAR_REFERENCE_SPAN_TRACKER_TOP_DEFINES_SVH
`define CIGAR_REFERENCE_SPAN_TRACKER_TOP_DEFINES_SVH

// Checks a property on every rising edge outside reset.
`define CSPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cspt assertion failed");

// Checks that a condition is never true outside reset.
`define CSPT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cspt forbidden condition seen");

`endif

@@ rtl/cspt_pkg.sv @@
// Package with the types, character codes and defaults of the span tracker.
package cspt_pkg;

  localparam int LENGTH_WIDTH_DEF = 32;
  localparam int IN_DEPTH_DEF     = 4;
  localparam int OUT_DEPTH_DEF    = 2;

  localparam logic [7:0] CH_NONE = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_P    = 8'h50;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_REF,
    OP_SKIP,
    OP_BAD
  } op_kind_t;

  typedef struct packed {
    logic [7:0]  cigar_char;
    logic        last_char;
    logic [30:0] read_pos;
    logic        is_mapped;
    logic        block_start;
  } in_item_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  digit;
    logic        last_char;
    logic [30:0] read_pos;
    logic        is_mapped;
    logic        block_start;
  } cls_item_t;

  typedef struct packed {
    logic [31:0] ref_length;
    logic [32:0] record_end;
    logic [30:0] span_start;
    logic        span_start_valid;
    logic [32:0] span_end;
    logic        bad_cigar;
    logic        record_mapped;
  } out_item_t;

endpackage

@@ rtl/cspt_queue.sv @@
// Small first-in first-out queue held in flip-flops.
`include "cigar_reference_span_tracker_top_defines.svh"

module cspt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `CSPT_NEVER(a_count_bound, clk, rst_n, count_r > CW'(DEPTH))
  `CSPT_ASSERT(a_count_up, clk, rst_n,
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + CW'(1)))
  `CSPT_ASSERT(a_count_down, clk, rst_n,
    (pop_ok && !push_ok) |=> (count_r == $past(count_r) - CW'(1)))

endmodule

@@ rtl/cspt_front.sv @@
// Front end: sorts each incoming character into an operation class.
module cspt_front
  import cspt_pkg::*;
(
  input  in_item_t  item,
  output cls_item_t cls
);

  logic [7:0] dig_off;

  assign dig_off = item.cigar_char - CH_ZERO;

  always_comb begin
    cls.digit       = dig_off[3:0];
    cls.last_char   = item.last_char;
    cls.read_pos    = item.read_pos;
    cls.is_mapped   = item.is_mapped;
    cls.block_start = item.block_start;
    // Unmapped records and NUL characters are passed through without parsing.
    if (!item.is_mapped || item.cigar_char == CH_NONE) begin
      cls.kind = OP_NONE;
    end else if (item.cigar_char >= CH_ZERO && item.cigar_char <= CH_NINE) begin
      cls.kind = OP_DIGIT;
    end else begin
      case (item.cigar_char)
        CH_M, CH_EQ, CH_X, CH_D, CH_N: cls.kind = OP_REF;
        CH_I, CH_S, CH_H, CH_P:        cls.kind = OP_SKIP;
        default:                       cls.kind = OP_BAD;
      endcase
    end
  end

endmodule

@@ rtl/cspt_back.sv @@
// Back end: length accumulation, record reporting and block span tracking.
`include "cigar_reference_span_tracker_top_defines.svh"

module cspt_back
  import cspt_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cls_item_t entry,
  input  logic      entry_valid,
  output logic      entry_pop,
  output out_item_t res,
  output logic      res_push,
  input  logic      res_full
);

  localparam int LW = LENGTH_WIDTH;

  logic [LW-1:0] op_acc_r, op_acc_nxt;
  logic [LW-1:0] ref_acc_r, ref_acc_nxt;
  logic          bad_r, bad_nxt;
  logic [30:0]   first_pos_r, first_pos_nxt;
  logic          have_first_r, have_first_nxt;
  logic [32:0]   max_end_r, max_end_nxt;

  logic [LW-1:0] op0, ref0, op1, ref1;
  logic          bad0, bad1, hf0;
  logic [30:0]   fp0;
  logic [32:0]   me0;
  logic [63:0]   ref_ext;
  logic [31:0]   len32;
  logic [32:0]   rec_end;
  logic          take;

  // A record's last character needs room in the result queue.
  assign take      = entry_valid && (!entry.last_char || !res_full);
  assign entry_pop = take;
  assign res_push  = take && entry.last_char;

  always_comb begin
    op0  = entry.block_start ? '0 : op_acc_r;
    ref0 = entry.block_start ? '0 : ref_acc_r;
    bad0 = entry.block_start ? 1'b0 : bad_r;
    fp0  = entry.block_start ? '0 : first_pos_r;
    hf0  = entry.block_start ? 1'b0 : have_first_r;
    me0  = entry.block_start ? '0 : max_end_r;

    op1  = op0;
    ref1 = ref0;
    bad1 = bad0;
    case (entry.kind)
      OP_DIGIT: op1 = (op0 << 3) + (op0 << 1) + LW'(entry.digit);
      OP_REF: begin
        ref1 = ref0 + op0;
        op1  = '0;
      end
      OP_SKIP: op1 = '0;
      OP_BAD: begin
        bad1 = 1'b1;
        op1  = '0;
      end
      default: op1 = op0;
    endcase

    ref_ext = 64'(ref1);
    len32   = ref_ext[31:0];
    rec_end = 33'(entry.read_pos) + 33'(len32);

    first_pos_nxt  = fp0;
    have_first_nxt = hf0;
    max_end_nxt    = me0;
    if (entry.last_char && entry.is_mapped && !bad1) begin
      if (!hf0) begin
        first_pos_nxt  = entry.read_pos;
        have_first_nxt = 1'b1;
      end
      if (rec_end > me0) begin
        max_end_nxt = rec_end;
      end
    end

    op_acc_nxt  = entry.last_char ? '0 : op1;
    ref_acc_nxt = entry.last_char ? '0 : ref1;
    bad_nxt     = entry.last_char ? 1'b0 : bad1;

    res.ref_length       = entry.is_mapped ? len32 : '0;
    res.record_end       = entry.is_mapped ? rec_end : '0;
    res.span_start       = first_pos_nxt;
    res.span_start_valid = have_first_nxt;
    res.span_end         = max_end_nxt;
    res.bad_cigar        = entry.is_mapped && bad1;
    res.record_mapped    = entry.is_mapped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_acc_r     <= '0;
      ref_acc_r    <= '0;
      bad_r        <= 1'b0;
      first_pos_r  <= '0;
      have_first_r <= 1'b0;
      max_end_r    <= '0;
    end else if (take) begin
      op_acc_r     <= op_acc_nxt;
      ref_acc_r    <= ref_acc_nxt;
      bad_r        <= bad_nxt;
      first_pos_r  <= first_pos_nxt;
      have_first_r <= have_first_nxt;
      max_end_r    <= max_end_nxt;
    end
  end

  `CSPT_ASSERT(a_span_covers_record, clk, rst_n,
    (res_push && res.record_mapped && !res.bad_cigar) |-> (res.span_end >= res.record_end))
  `CSPT_ASSERT(a_first_pos_clears_on_block, clk, rst_n,
    $fell(have_first_r) |-> $past(take && entry.block_start))
  `CSPT_ASSERT(a_record_clears, clk, rst_n,
    (take && entry.last_char) |=> (op_acc_r == '0 && ref_acc_r == '0 && !bad_r))

endmodule

@@ rtl/cigar_reference_span_tracker_top.sv @@
// Top level of the CIGAR reference span tracker.
//
// The block takes CIGAR text one character per request on the input queue
// port: push a request while full is low. Each request carries the character,
// a last-character mark, the record position, the mapped flag and a
// block-start mark. A request with the last-character mark set produces one
// result on the output queue port; other requests produce none.
// A result is waiting while empty is low and is taken with pop.
// Throughput is one request per cycle, sustained, as long as results are
// taken. A result is written into the output queue at the edge that takes
// its last character from the request queue. The rate is set by the update
// of the length accumulators (a multiply by ten done as two shifts and an add).
// Between the classifier and the accumulator sits a four-entry request queue,
// and results wait in a two-entry output queue. When the receiver stalls, the
// output queue fills, the accumulator stops at the next last character, the
// request queue fills and full rises. Reset clears all accumulators, the span
// state and both queues; the block takes requests in the first cycle after it.

module cigar_reference_span_tracker_top
  import cspt_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
  parameter int IN_DEPTH     = IN_DEPTH_DEF,
  parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_data,
  output logic      full,
  input  logic      pop,
  output out_item_t out_data,
  output logic      empty
);

  cls_item_t cls;
  cls_item_t entry;
  logic      entry_empty;
  logic      entry_pop;
  out_item_t res;
  logic      res_push;
  logic      res_full;

  // Front end: classify the character before it enters the request queue.
  cspt_front u_front (
    .item (in_data),
    .cls  (cls)
  );

  cspt_queue #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (cls),
    .full    (full),
    .pop     (entry_pop),
    .rd_data (entry),
    .empty   (entry_empty)
  );

  // Back end: accumulate lengths and keep the block span.
  cspt_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (entry),
    .entry_valid (!entry_empty),
    .entry_pop   (entry_pop),
    .res         (res),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  cspt_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule
